/* sv/adcvm_pkg.sv */
// ============================================================================
// adcvm_pkg: shared types and constants of the seven-segment voltmeter scan
// Field widths, command and digit structures, the segment table and the
// decimal digit split used by the front and back parts of the block.
// ============================================================================
`default_nettype none

package adcvm_pkg;

   // Field widths.
   localparam int SampleW = 10;
   localparam int ValueW  = 9;
   localparam int DwellW  = 16;
   localparam int SegW    = 8;
   localparam int DigitW  = 4;
   localparam int DIGITS  = 3;
   localparam int ScanW   = 2;

   // Scaling constants: hundredths of a volt per full-scale reading.
   localparam int FullScale = 500;
   localparam int ConvMax   = 1023;
   localparam int ProdW     = SampleW + ValueW;

   localparam logic [DwellW-1:0] DWELL_RESET = 16'd5;

   // Command codes carried by the func field.
   typedef enum logic {
      FUNC_SAMPLE = 1'b0,
      FUNC_TICK   = 1'b1
   } func_type;

   // One queued command: a tick, or a sample already scaled to hundredths.
   typedef struct packed {
      func_type          func;
      logic [ValueW-1:0] value;
   } cmd_type;

   // Fill status of the command queue.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Three decimal digits of a held value.
   typedef struct packed {
      logic [DigitW-1:0] hundreds;
      logic [DigitW-1:0] tens;
      logic [DigitW-1:0] units;
   } digits_type;

   // Active-high segments a..g for a decimal digit; anything else is dark.
   function automatic logic [6:0] seg_lit(input logic [DigitW-1:0] d);
      logic [6:0] pat;
      unique case (d)
         4'd0:    pat = 7'h3F;
         4'd1:    pat = 7'h06;
         4'd2:    pat = 7'h5B;
         4'd3:    pat = 7'h4F;
         4'd4:    pat = 7'h66;
         4'd5:    pat = 7'h6D;
         4'd6:    pat = 7'h7D;
         4'd7:    pat = 7'h07;
         4'd8:    pat = 7'h7F;
         4'd9:    pat = 7'h6F;
         default: pat = 7'h00;
      endcase
      return pat;
   endfunction

   // Split a value of at most 500 into hundreds, tens and units.
   // Hundreds come from a compare chain, tens from a reciprocal multiply
   // (x * 205 >> 11 is exact for x below 1029).
   function automatic digits_type split_value(input logic [ValueW-1:0] v);
      digits_type        res;
      logic [ValueW-1:0] rem;
      logic [17:0]       prod;
      logic [6:0]        tens_x10;
      if (v >= 9'd500)      res.hundreds = 4'd5;
      else if (v >= 9'd400) res.hundreds = 4'd4;
      else if (v >= 9'd300) res.hundreds = 4'd3;
      else if (v >= 9'd200) res.hundreds = 4'd2;
      else if (v >= 9'd100) res.hundreds = 4'd1;
      else                  res.hundreds = 4'd0;
      rem      = v - ValueW'(res.hundreds) * 9'd100;
      prod     = 18'(rem) * 18'd205;
      res.tens = DigitW'(prod >> 11);
      tens_x10 = 7'(res.tens) * 7'd10;
      res.units = DigitW'(rem - ValueW'(tens_x10));
      return res;
   endfunction

endpackage

`default_nettype wire

/* sv/adcvm_req_if.sv */
// ============================================================================
// adcvm_req_if: input channel of the voltmeter scan
// Valid/ready handshake carrying the command code and the converter reading.
// ============================================================================
`default_nettype none

interface adcvm_req_if;
   import adcvm_pkg::*;

   logic               valid;
   logic               ready;
   logic               func;
   logic [SampleW-1:0] sample;

   modport source (output valid, output func, output sample, input ready);
   modport sink   (input valid, input func, input sample, output ready);
endinterface

`default_nettype wire

/* sv/adcvm_rsp_if.sv */
// ============================================================================
// adcvm_rsp_if: result channel of the voltmeter scan
// Valid/ready handshake carrying segments, digit enable and the held value.
// ============================================================================
`default_nettype none

interface adcvm_rsp_if;
   import adcvm_pkg::*;

   logic              valid;
   logic              ready;
   logic [SegW-1:0]   segments_n;
   logic [DIGITS-1:0] digit_enable;
   logic [ValueW-1:0] shown_value;

   modport source (output valid, output segments_n, output digit_enable,
                   output shown_value, input ready);
   modport sink   (input valid, input segments_n, input digit_enable,
                   input shown_value, output ready);
endinterface

`default_nettype wire

/* sv/adcvm_front.sv */
// ============================================================================
// adcvm_front: transaction intake and sample scaling
// Accepts input transactions while the queue has room, classifies them and
// scales a sample to hundredths of a volt before it enters the queue.
// ============================================================================
`default_nettype none

module adcvm_front (
   adcvm_req_if.sink                   req_if,
   input  adcvm_pkg::q_status_type     q_status,
   output logic                        push,
   output adcvm_pkg::cmd_type          push_data
);
   import adcvm_pkg::*;

   logic [ProdW-1:0]  prod;
   logic [ValueW-1:0] q_est;
   logic [ProdW-1:0]  rem;
   logic [ValueW:0]   q_fix;
   logic [ValueW-1:0] scaled;

   // Intake: one transaction per cycle while the queue is not full.
   assign req_if.ready = !q_status.full;
   assign push         = req_if.valid && !q_status.full;

   // Divide by 1023: x >> 10 is the quotient or one below it, so a single
   // remainder compare finishes the job.
   always_comb begin
      prod  = ProdW'(req_if.sample) * ProdW'(FullScale);
      q_est = prod[ProdW-1:10];
      rem   = prod - {q_est, 10'b0} + ProdW'(q_est);
      if (rem >= ProdW'(ConvMax)) q_fix = {1'b0, q_est} + 1'b1;
      else                        q_fix = {1'b0, q_est};
      // Cap at full scale.
      if (q_fix > (ValueW + 1)'(FullScale)) scaled = ValueW'(FullScale);
      else                                  scaled = q_fix[ValueW-1:0];
   end

   // Classify the transaction into a queued command.
   always_comb begin
      push_data.func  = func_type'(req_if.func);
      push_data.value = (req_if.func == FUNC_SAMPLE) ? scaled : '0;
   end

endmodule

`default_nettype wire

/* sv/adcvm_queue.sv */
// ============================================================================
// adcvm_queue: two-entry command queue
// Decouples intake from the display state update so each side stalls alone.
// ============================================================================
`default_nettype none

module adcvm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  adcvm_pkg::cmd_type       push_data,
   input  logic                     pop,
   output adcvm_pkg::cmd_type       pop_data,
   output adcvm_pkg::q_status_type  q_status
);
   import adcvm_pkg::*;

   localparam int Depth = 2;

   cmd_type    entry_ff [Depth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == 2'(Depth));
   assign q_status.empty = (count_ff == 2'd0);
   assign pop_data       = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* sv/adcvm_back.sv */
// ============================================================================
// adcvm_back: display state and result register
// Applies queued commands to the digit store, dwell counter and scan
// position, and registers the segment pattern of the digit now scanned.
// ============================================================================
`default_nettype none

module adcvm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [adcvm_pkg::DwellW-1:0]      csr_wdata,
   input  adcvm_pkg::cmd_type                pop_data,
   input  adcvm_pkg::q_status_type           q_status,
   output logic                              pop,
   adcvm_rsp_if.source                       rsp_if
);
   import adcvm_pkg::*;

   logic [DwellW-1:0] dwell_ticks_ff;
   logic [DigitW-1:0] digit_ff [DIGITS];
   logic [DigitW-1:0] digit_in [DIGITS];
   logic [ScanW-1:0]  scan_ff, scan_in;
   logic [DwellW-1:0] dwell_ff, dwell_in;
   logic [ValueW-1:0] held_ff, held_in;

   logic              rsp_valid_ff;
   logic [SegW-1:0]   seg_ff, seg_in;
   logic [DIGITS-1:0] en_ff, en_in;
   logic [ValueW-1:0] val_ff;

   logic [DwellW-1:0] limit;
   logic [DwellW:0]   next_count;
   logic              advance;
   digits_type        split;
   logic [SegW-1:0]   lit;

   // Take a command whenever the result register is free or being drained.
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_if.ready);

   // Dwell limit; a zero setting behaves as one.
   always_comb begin
      limit      = (dwell_ticks_ff == '0) ? DwellW'(1) : dwell_ticks_ff;
      next_count = {1'b0, dwell_ff} + 1'b1;
      advance    = (next_count >= {1'b0, limit});
      split      = split_value(pop_data.value);
   end

   // Next display state.
   always_comb begin
      held_in  = held_ff;
      scan_in  = scan_ff;
      dwell_in = dwell_ff;
      for (int i = 0; i < DIGITS; i++) begin
         digit_in[i] = digit_ff[i];
      end
      if (pop) begin
         if (pop_data.func == FUNC_SAMPLE) begin
            held_in     = pop_data.value;
            digit_in[0] = split.hundreds;
            digit_in[1] = split.tens;
            digit_in[2] = split.units;
         end else if (advance) begin
            dwell_in = '0;
            if (32'(scan_ff) + 1 < DIGITS) scan_in = scan_ff + 1'b1;
            else                          scan_in = '0;
         end else begin
            dwell_in = next_count[DwellW-1:0];
         end
      end
   end

   // Segment pattern and enable for the digit scanned after this command.
   // The decimal point sits on the first digit.
   always_comb begin
      lit   = '0;
      en_in = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (scan_in == ScanW'(i)) begin
            lit[6:0] = seg_lit(digit_in[i]);
            en_in[i] = 1'b1;
         end
      end
      if (scan_in == '0) lit[7] = 1'b1;
      seg_in = ~lit;
   end

   // Control and display state.
   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ticks_ff <= DWELL_RESET;
         scan_ff        <= '0;
         dwell_ff       <= '0;
         held_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < DIGITS; i++) begin
            digit_ff[i] <= '0;
         end
      end else begin
         if (csr_we) dwell_ticks_ff <= csr_wdata;
         scan_ff  <= scan_in;
         dwell_ff <= dwell_in;
         held_ff  <= held_in;
         for (int i = 0; i < DIGITS; i++) begin
            digit_ff[i] <= digit_in[i];
         end
         if (pop)                rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready)  rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (pop) begin
         seg_ff <= seg_in;
         en_ff  <= en_in;
         val_ff <= held_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.segments_n   = seg_ff;
   assign rsp_if.digit_enable = en_ff;
   assign rsp_if.shown_value  = val_ff;

   // A presented result always lights exactly one digit.
   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(en_ff))
      else $error("result without exactly one digit enable");

   // A sample command is reflected in the held value and the result.
   a_sample_held: assert property (@(posedge clock) disable iff (reset)
      pop && pop_data.func == FUNC_SAMPLE |=>
         held_ff == $past(pop_data.value) && val_ff == held_ff)
      else $error("sample not held");

   // Samples never move the scan.
   a_sample_scan: assert property (@(posedge clock) disable iff (reset)
      pop && pop_data.func == FUNC_SAMPLE |=> $stable(scan_ff) && $stable(dwell_ff))
      else $error("sample moved the scan");

   // A tick below the dwell limit leaves the scan position alone.
   a_tick_hold: assert property (@(posedge clock) disable iff (reset)
      pop && pop_data.func == FUNC_TICK && !advance |=> $stable(scan_ff))
      else $error("scan moved before dwell expired");

   // Without a command the display state holds.
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !pop |=> $stable(scan_ff) && $stable(held_ff) && $stable(dwell_ff))
      else $error("display state changed without a command");

endmodule

`default_nettype wire

/* sv/adc_voltmeter_seven_segment_scan.sv */
// ============================================================================
// adc_voltmeter_seven_segment_scan: multiplexed voltmeter display scanner
// Converts converter samples to three decimal digits and scans them one at a
// time onto a common-anode seven-segment display, paced by time ticks.
// ============================================================================
//
//   Channel   Direction  Handshake      Contents
//   req_if    in         valid/ready    func, sample
//   rsp_if    out        valid/ready    segments_n, digit_enable, shown_value
//   csr_*     in         write enable   dwell_ticks (16 bits)
//
// One transaction per cycle is accepted while the queue is not full; each
// passes through the queue write, then the result register, to its result.
// The sample scaling sets the front path; the digit split and segment lookup
// set the back path. Reset is synchronous and active high; it restores a
// dwell of 5 and clears digits, scan and value. A stalled result holds the
// back part, and intake continues until the two-entry queue is full.
//
`default_nettype none

module adc_voltmeter_seven_segment_scan (
   input  logic                           clock,
   input  logic                           reset,
   adcvm_req_if.sink                      req_if,
   adcvm_rsp_if.source                    rsp_if,
   input  logic                           csr_we,
   input  logic [adcvm_pkg::DwellW-1:0]   csr_wdata
);
   import adcvm_pkg::*;

   logic         push;
   cmd_type      push_data;
   logic         pop;
   cmd_type      pop_data;
   q_status_type q_status;

   adcvm_front u_front (
      .req_if    (req_if),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   adcvm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   adcvm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .pop_data  (pop_data),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire
